// ===== rtl/multitap_echo_history_buffer_macros.svh =====
// Assertion macros shared by the echo history buffer RTL.
// Each checks on the rising edge of clock and is off while reset is high.
`ifndef MULTITAP_ECHO_HISTORY_BUFFER_MACROS_SVH
`define MULTITAP_ECHO_HISTORY_BUFFER_MACROS_SVH
`ifndef SYNTHESIS
`define MEHB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mehb: check failed");
`define MEHB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mehb: check failed");
`else
`define MEHB_ASSERT_IMPL(label, ante, cons)
`define MEHB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/mehb_pkg.sv =====
// Shared types, widths and arithmetic helpers for the echo history buffer.
// No dependencies.
`default_nettype none

package mehb_pkg;

   localparam int unsigned ADDR_W       = 16;
   localparam int unsigned BUFFER_DEPTH = 1 << ADDR_W;
   localparam int unsigned MAX_ECHOES   = 4;
   localparam int unsigned NUM_GAINS    = 4;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned STORE_W    = 2 * SAMPLE_W;
   localparam int unsigned VOL_W      = 16;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned COUNT_W    = 3;
   localparam int unsigned SPACING_W  = 14;
   localparam int unsigned FRAMES_W   = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam int unsigned TAP_W   = $clog2(MAX_ECHOES + 1);
   localparam int unsigned DELAY_W = $clog2(MAX_ECHOES * ((1 << SPACING_W) - 1) + 1);
   localparam int unsigned POS_W   = (ADDR_W > DELAY_W) ? ADDR_W : DELAY_W;

   // tap coefficient is gain * volume; main term uses volume << MAIN_SHIFT
   localparam int unsigned COEF_W     = VOL_W + GAIN_W;
   localparam int unsigned MAIN_SHIFT = GAIN_W - 1;
   localparam int unsigned FRAC_W     = (VOL_W - 1) + (GAIN_W - 1);
   localparam int unsigned PROD_W     = SAMPLE_W + COEF_W + 1;
   localparam int unsigned TERM_W     = SAMPLE_W + 3;
   localparam int unsigned ACC_W      = SAMPLE_W + 4;

   localparam logic [VOL_W-1:0]     RST_MASTER_VOLUME = VOL_W'(32768);
   localparam logic [SPACING_W-1:0] RST_ECHO_SPACING  = SPACING_W'(1);

   localparam logic signed [ACC_W-1:0] ACC_SAT_HI = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] ACC_SAT_LO = ACC_W'(-(2 ** (SAMPLE_W - 1)));
   localparam logic signed [PROD_W-1:0] TRUNC_BIAS =
      PROD_W'((PROD_W'(1) << FRAC_W) - PROD_W'(1));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASTER_VOLUME = 3'd0,
      CSR_ECHO_ENABLE   = 3'd1,
      CSR_ECHO_COUNT    = 3'd2,
      CSR_ECHO_SPACING  = 3'd3,
      CSR_TAP_GAIN_0    = 3'd4,
      CSR_TAP_GAIN_1    = 3'd5,
      CSR_TAP_GAIN_2    = 3'd6,
      CSR_TAP_GAIN_3    = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_TAPS   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_left;
      logic signed [SAMPLE_W-1:0] sample_right;
      logic                       last_source;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
   } rsp_type;

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > ACC_SAT_HI) begin
         r = ACC_SAT_HI[SAMPLE_W-1:0];
      end else if (v < ACC_SAT_LO) begin
         r = ACC_SAT_LO[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // divide by 2^FRAC_W, rounding toward zero
   function automatic logic signed [TERM_W-1:0] trunc_term(
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] adj;
      adj = p + (p[PROD_W-1] ? TRUNC_BIAS : '0);
      return adj[FRAC_W+TERM_W-1:FRAC_W];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mehb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module mehb_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/multitap_echo_history_buffer.sv =====
// Stereo mix history store with multi-tap echo; uses mehb_pkg, mehb_ram.
// Non-closing items are only summed into the mix and never hold off the input. A closing
// item stores the mix, then reads the main term and the echo taps through the single
// read port of the history store (one tap read per cycle); no new item is taken until
// the result is loaded into a free result slot. Reset: synchronous; a clearing pass
// zeroes the store, during which no item is taken (configuration writes still are).
`default_nettype none
`include "multitap_echo_history_buffer_macros.svh"

module multitap_echo_history_buffer import mehb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration
   logic [VOL_W-1:0]     master_volume_ff;
   logic                 echo_enable_ff;
   logic [COUNT_W-1:0]   echo_count_ff;
   logic [SPACING_W-1:0] echo_spacing_ff;
   logic [GAIN_W-1:0]    tap_gain_ff [NUM_GAINS];

   // control
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]   wp_ff, wp_in;
   logic [FRAMES_W-1:0] frames_ff, frames_in;
   logic [TAP_W-1:0]    tap_ff, tap_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic                iss_v_ff, iss_v_in;
   logic                mul_v_ff, mul_v_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [SAMPLE_W-1:0] accum_left_ff, accum_left_in;
   logic signed [SAMPLE_W-1:0] accum_right_ff, accum_right_in;
   logic [COEF_W-1:0]          coef_ff, coef_in;
   logic signed [PROD_W-1:0]   prod_left_ff, prod_left_in;
   logic signed [PROD_W-1:0]   prod_right_ff, prod_right_in;
   logic signed [SAMPLE_W-1:0] sum_left_ff, sum_left_in;
   logic signed [SAMPLE_W-1:0] sum_right_ff, sum_right_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   // store port
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [STORE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [STORE_W-1:0] ram_rd_data;

   logic                       req_fire;
   logic [ADDR_W-1:0]          rp;
   logic [ADDR_W-1:0]          wp_inc;
   logic signed [SAMPLE_W-1:0] mix_left;
   logic signed [SAMPLE_W-1:0] mix_right;
   logic                       tap_active;
   logic [ADDR_W-1:0]          tap_pos;
   logic [GAIN_W-1:0]          gain;
   logic                       pipe_idle;
   logic                       rsp_free;
   logic                       rsp_load;
   logic signed [SAMPLE_W-1:0] rd_left;
   logic signed [SAMPLE_W-1:0] rd_right;
   logic signed [TERM_W-1:0]   term_left;
   logic signed [TERM_W-1:0]   term_right;

   mehb_ram #(
      .WIDTH (STORE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_fire  = req_valid && req_ready;

   assign rp     = wp_ff - ADDR_W'(1);
   assign wp_inc = wp_ff + ADDR_W'(1);

   assign mix_left  = sat_sample(ACC_W'(accum_left_ff) + ACC_W'(req_data.sample_left));
   assign mix_right = sat_sample(ACC_W'(accum_right_ff) + ACC_W'(req_data.sample_right));

   assign tap_active = echo_enable_ff
                    && (32'(tap_ff) < 32'(echo_count_ff))
                    && (32'(frames_ff) >= 32'(delay_ff));
   assign tap_pos    = ADDR_W'(POS_W'(rp) - POS_W'(delay_ff));

   always_comb begin
      gain = '0;
      for (int k = 0; k < NUM_GAINS; k++) begin
         if (32'(tap_ff) == k) begin
            gain = tap_gain_ff[k];
         end
      end
   end

   assign pipe_idle = !iss_v_ff && !mul_v_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == S_FINISH) && pipe_idle && rsp_free;

   // multiply stage and truncating accumulate stage
   assign rd_left       = ram_rd_data[SAMPLE_W-1:0];
   assign rd_right      = ram_rd_data[STORE_W-1:SAMPLE_W];
   assign prod_left_in  = PROD_W'(rd_left) * PROD_W'($signed({1'b0, coef_ff}));
   assign prod_right_in = PROD_W'(rd_right) * PROD_W'($signed({1'b0, coef_ff}));
   assign mul_v_in      = iss_v_ff;
   assign term_left     = trunc_term(prod_left_ff);
   assign term_right    = trunc_term(prod_right_ff);

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      wp_in          = wp_ff;
      frames_in      = frames_ff;
      tap_in         = tap_ff;
      delay_in       = delay_ff;
      iss_v_in       = 1'b0;
      coef_in        = coef_ff;
      accum_left_in  = accum_left_ff;
      accum_right_in = accum_right_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = wp_ff;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rp;
      sum_left_in    = sum_left_ff;
      sum_right_in   = sum_right_ff;

      if (mul_v_ff) begin
         sum_left_in  = sat_sample(ACC_W'(sum_left_ff) + ACC_W'(term_left));
         sum_right_in = sat_sample(ACC_W'(sum_right_ff) + ACC_W'(term_right));
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.last_source) begin
                  ram_wr_en      = 1'b1;
                  ram_wr_addr    = wp_ff;
                  ram_wr_data    = {mix_right, mix_left};
                  accum_left_in  = '0;
                  accum_right_in = '0;
                  ram_rd_en      = 1'b1;
                  ram_rd_addr    = rp;
                  iss_v_in       = 1'b1;
                  coef_in        = COEF_W'(master_volume_ff) << MAIN_SHIFT;
                  sum_left_in    = '0;
                  sum_right_in   = '0;
                  tap_in         = '0;
                  delay_in       = DELAY_W'(echo_spacing_ff);
                  state_in       = S_TAPS;
               end else begin
                  accum_left_in  = mix_left;
                  accum_right_in = mix_right;
               end
            end
         end
         S_TAPS: begin
            ram_rd_en   = tap_active;
            ram_rd_addr = tap_pos;
            iss_v_in    = tap_active;
            coef_in     = COEF_W'(gain) * COEF_W'(master_volume_ff);
            tap_in      = tap_ff + TAP_W'(1);
            delay_in    = delay_ff + DELAY_W'(echo_spacing_ff);
            if (tap_ff == TAP_W'(MAX_ECHOES - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_left: sum_left_ff, out_right: sum_right_ff};
               ram_wr_en    = 1'b1;
               ram_wr_addr  = wp_inc;
               wp_in        = wp_inc;
               if (frames_ff != '1) begin
                  frames_in = frames_ff + FRAMES_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in    = S_CLEAR;
            clr_addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_addr_ff    <= '0;
         wp_ff          <= ADDR_W'(1);
         frames_ff      <= '0;
         tap_ff         <= '0;
         delay_ff       <= '0;
         iss_v_ff       <= 1'b0;
         mul_v_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         accum_left_ff  <= '0;
         accum_right_ff <= '0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         wp_ff          <= wp_in;
         frames_ff      <= frames_in;
         tap_ff         <= tap_in;
         delay_ff       <= delay_in;
         iss_v_ff       <= iss_v_in;
         mul_v_ff       <= mul_v_in;
         rsp_valid_ff   <= rsp_valid_in;
         accum_left_ff  <= accum_left_in;
         accum_right_ff <= accum_right_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff       <= coef_in;
      prod_left_ff  <= prod_left_in;
      prod_right_ff <= prod_right_in;
      sum_left_ff   <= sum_left_in;
      sum_right_ff  <= sum_right_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_volume_ff <= RST_MASTER_VOLUME;
         echo_enable_ff   <= 1'b0;
         echo_count_ff    <= '0;
         echo_spacing_ff  <= RST_ECHO_SPACING;
         for (int k = 0; k < NUM_GAINS; k++) begin
            tap_gain_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MASTER_VOLUME: master_volume_ff <= csr_data[VOL_W-1:0];
            CSR_ECHO_ENABLE:   echo_enable_ff   <= csr_data[0];
            CSR_ECHO_COUNT:    echo_count_ff    <= csr_data[COUNT_W-1:0];
            CSR_ECHO_SPACING:  echo_spacing_ff  <= csr_data[SPACING_W-1:0];
            CSR_TAP_GAIN_0:    tap_gain_ff[0]   <= csr_data[GAIN_W-1:0];
            CSR_TAP_GAIN_1:    tap_gain_ff[1]   <= csr_data[GAIN_W-1:0];
            CSR_TAP_GAIN_2:    tap_gain_ff[2]   <= csr_data[GAIN_W-1:0];
            CSR_TAP_GAIN_3:    tap_gain_ff[3]   <= csr_data[GAIN_W-1:0];
         endcase
      end
   end

   `MEHB_ASSERT_IMPL(a_no_same_slot_rw, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)
   `MEHB_ASSERT_IMPL(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff == S_FINISH))
   `MEHB_ASSERT_NEXT(a_wp_step, rsp_load, wp_ff == ADDR_W'($past(wp_ff) + ADDR_W'(1)))
   `MEHB_ASSERT_IMPL(a_accum_clear, state_ff == S_TAPS, accum_left_ff == '0 && accum_right_ff == '0)
   `MEHB_ASSERT_IMPL(a_tap_bound, state_ff == S_TAPS, 32'(tap_ff) < MAX_ECHOES)

endmodule

`default_nettype wire
